[hw/rtl/crpu_pkg.sv]
// ----------------------------------------------------------------------------
// crpu_pkg
// Shared types, constants and constant functions of the complex
// rectangular/polar unit.
// ----------------------------------------------------------------------------
package crpu_pkg;

  localparam int GUARD = 16;
  localparam int CW = 52;
  localparam int ZW = 34;
  localparam int RW = CW - GUARD;
  localparam int IK_W = 31;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MUL  = 2'd1,
    OP_CONV = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic        polar;
    logic [31:0] first;
    logic [31:0] second;
  } operand_t;

  typedef struct packed {
    op_t      op;
    operand_t a;
    operand_t b;
  } cmd_t;

  function automatic logic [31:0] atan_at(input int unsigned i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051D;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2E;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2F9;
      15: return 32'h0000517C;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A2F;
      19: return 32'h00000517;
      20: return 32'h0000028B;
      21: return 32'h00000145;
      22: return 32'h000000A2;
      23: return 32'h00000051;
      24: return 32'h00000028;
      25: return 32'h00000014;
      26: return 32'h0000000A;
      27: return 32'h00000005;
      28: return 32'h00000002;
      29: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

  // CORDIC gain in Q30, square root of the truncated gain product.
  function automatic logic [63:0] gain_k(input int steps);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bit_v;
    p = 64'd1 << 30;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 62) p = p + (p >> (2 * i));
    end
    v = p << 30;
    r = 64'd0;
    bit_v = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + bit_v) begin
        v = v - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    if (r == 64'd0) r = 64'd1;
    return r;
  endfunction

endpackage

[hw/rtl/crpu_front.sv]
// ----------------------------------------------------------------------------
// crpu_front
// Decodes the operation and normalizes polar operands to a non-negative
// magnitude before they enter the command queue.
// ----------------------------------------------------------------------------
module crpu_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [127:0]    s_tdata,
  input  logic [3:0]      s_tuser,
  output logic            q_valid,
  input  logic            q_ready,
  output crpu_pkg::cmd_t  q_cmd
);
  import crpu_pkg::*;

  function automatic operand_t classify(input logic polar, input logic [31:0] first,
                                        input logic [31:0] second);
    operand_t r;
    r.polar = polar;
    r.first = first;
    r.second = second;
    if (polar && first[31]) begin
      r.first = 32'd0 - first;
      r.second = second + 32'h8000_0000;
    end
    return r;
  endfunction

  assign s_tready = q_ready;
  assign q_valid = s_tvalid;

  always_comb begin
    q_cmd.op = op_t'(s_tuser[1:0]);
    q_cmd.a = classify(s_tuser[2], s_tdata[31:0], s_tdata[63:32]);
    q_cmd.b = classify(s_tuser[3], s_tdata[95:64], s_tdata[127:96]);
  end

endmodule

[hw/rtl/crpu_queue.sv]
// ----------------------------------------------------------------------------
// crpu_queue
// Short command queue between the front end and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module crpu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  crpu_pkg::cmd_t  in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output crpu_pkg::cmd_t  out_cmd
);
  import crpu_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hw/rtl/crpu_cordic.sv]
// ----------------------------------------------------------------------------
// crpu_cordic
// Pipelined CORDIC with gain correction, one stage per iteration. Each item
// selects rotation (magnitude and angle in) or vectoring (real and imaginary
// in).
// ----------------------------------------------------------------------------
module crpu_cordic #(
  parameter int STEPS = 32,
  parameter int TAG_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic                            in_vec,
  input  logic signed [32:0]              in_x,
  input  logic [31:0]                     in_y,
  input  logic [TAG_W-1:0]                in_tag,
  output logic                            out_valid,
  output logic signed [crpu_pkg::RW-1:0]  out_re,
  output logic signed [crpu_pkg::RW-1:0]  out_im,
  output logic [32:0]                     out_mag,
  output logic [31:0]                     out_ang,
  output logic [TAG_W-1:0]                out_tag
);
  import crpu_pkg::*;

  localparam int HI_W = CW - 30;
  localparam int PH_W = HI_W + IK_W;
  localparam int PL_W = 30 + IK_W;
  localparam logic [63:0] K_GAIN = gain_k(STEPS);
  localparam logic [63:0] INV_FULL = 64'h1000_0000_0000_0000 / K_GAIN;
  localparam logic [IK_W-1:0] INV_GAIN = INV_FULL[IK_W-1:0];

  logic                    p1_valid;
  logic                    p1_vec;
  logic signed [32:0]      p1_x;
  logic [31:0]             p1_y;
  logic [TAG_W-1:0]        p1_tag;
  logic [PH_W-1:0]         p1_ph;
  logic [PL_W-1:0]         p1_pl;

  logic [PL_W:0]           p2_lo_r;
  logic [CW-1:0]           p2_scaled;
  logic [31:0]             p2_ang_q;
  logic                    p2_fold;
  logic [31:0]             p2_za;
  logic signed [CW-1:0]    p2_vx;
  logic signed [CW-1:0]    p2_vy;

  logic                    valid_s [STEPS+1];
  logic                    vec_s [STEPS+1];
  logic                    zero_s [STEPS+1];
  logic                    base_s [STEPS+1];
  logic signed [CW-1:0]    x_s [STEPS+1];
  logic signed [CW-1:0]    y_s [STEPS+1];
  logic signed [ZW-1:0]    z_s [STEPS+1];
  logic [TAG_W-1:0]        tag_s [STEPS+1];

  logic [CW-2:0]           q_xc;
  logic [CW-1:0]           q_xr;
  logic [CW-1:0]           q_yr;
  logic                    q1_valid;
  logic                    q1_vec;
  logic                    q1_zero;
  logic signed [RW-1:0]    q1_re;
  logic signed [RW-1:0]    q1_im;
  logic [PH_W-1:0]         q1_ph;
  logic [PL_W-1:0]         q1_pl;
  logic [31:0]             q1_ang;
  logic [TAG_W-1:0]        q1_tag;
  logic [PL_W:0]           q2_lo_r;
  logic [PH_W:0]           q2_sc;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_vec <= in_vec;
      p1_x <= in_x;
      p1_y <= in_y;
      p1_tag <= in_tag;
      p1_ph <= PH_W'(in_x[31:14]) * PH_W'(INV_GAIN);
      p1_pl <= PL_W'({in_x[13:0], 16'd0}) * PL_W'(INV_GAIN);
    end
  end

  always_comb begin
    p2_lo_r = {1'b0, p1_pl} + (PL_W + 1)'(64'd1 << 29);
    p2_scaled = CW'(p1_ph) + CW'(p2_lo_r >> 30);
    p2_ang_q = p1_y + 32'h4000_0000;
    p2_fold = p2_ang_q > 32'h8000_0000;
    p2_za = p2_fold ? p1_y + 32'h8000_0000 : p1_y;
    p2_vx = {{(CW - 49){p1_x[32]}}, p1_x, 16'd0};
    p2_vy = {{(CW - 48){p1_y[31]}}, p1_y, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s[0] <= 1'b0;
    end else if (en) begin
      valid_s[0] <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_s[0] <= p1_vec;
      tag_s[0] <= p1_tag;
      zero_s[0] <= (p1_x == '0) && (p1_y == '0);
      if (p1_vec) begin
        base_s[0] <= p1_x[32];
        x_s[0] <= p1_x[32] ? -p2_vx : p2_vx;
        y_s[0] <= p1_x[32] ? -p2_vy : p2_vy;
        z_s[0] <= '0;
      end else begin
        base_s[0] <= 1'b0;
        x_s[0] <= p2_fold ? -$signed(p2_scaled) : $signed(p2_scaled);
        y_s[0] <= '0;
        z_s[0] <= {{(ZW - 32){p2_za[31]}}, p2_za};
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [31:0] ATAN_W = atan_at(i);
    localparam logic signed [ZW-1:0] ATAN = {{(ZW - 32){1'b0}}, ATAN_W};
    logic                 dir_pos;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = x_s[i] >>> i;
    assign ys = y_s[i] >>> i;
    assign dir_pos = vec_s[i] ? y_s[i][CW-1] : !z_s[i][ZW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_s[i+1] <= 1'b0;
      end else if (en) begin
        valid_s[i+1] <= valid_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec_s[i+1] <= vec_s[i];
        zero_s[i+1] <= zero_s[i];
        base_s[i+1] <= base_s[i];
        tag_s[i+1] <= tag_s[i];
        if (dir_pos) begin
          x_s[i+1] <= x_s[i] - ys;
          y_s[i+1] <= y_s[i] + xs;
          z_s[i+1] <= z_s[i] - ATAN;
        end else begin
          x_s[i+1] <= x_s[i] + ys;
          y_s[i+1] <= y_s[i] - xs;
          z_s[i+1] <= z_s[i] + ATAN;
        end
      end
    end
  end

  always_comb begin
    q_xc = x_s[STEPS][CW-1] ? '0 : x_s[STEPS][CW-2:0];
    q_xr = x_s[STEPS] + CW'(64'd1 << (GUARD - 1));
    q_yr = y_s[STEPS] + CW'(64'd1 << (GUARD - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
    end else if (en) begin
      q1_valid <= valid_s[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_vec <= vec_s[STEPS];
      q1_zero <= zero_s[STEPS];
      q1_tag <= tag_s[STEPS];
      q1_re <= q_xr[CW-1:GUARD];
      q1_im <= q_yr[CW-1:GUARD];
      q1_ph <= PH_W'(q_xc[CW-2:30]) * PH_W'(INV_GAIN);
      q1_pl <= PL_W'(q_xc[29:0]) * PL_W'(INV_GAIN);
      q1_ang <= {base_s[STEPS], 31'd0} + z_s[STEPS][31:0];
    end
  end

  always_comb begin
    q2_lo_r = {1'b0, q1_pl} + (PL_W + 1)'(64'd1 << 29);
    q2_sc = (PH_W + 1)'(q1_ph) + (PH_W + 1)'(q2_lo_r >> 30)
            + (PH_W + 1)'(64'd1 << (GUARD - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= q1_tag;
      out_re <= q1_re;
      out_im <= q1_im;
      if (q1_vec && q1_zero) begin
        out_mag <= '0;
        out_ang <= '0;
      end else begin
        out_mag <= q2_sc[GUARD+32:GUARD];
        out_ang <= q1_ang;
      end
    end
  end

endmodule

[hw/rtl/crpu_back.sv]
// ----------------------------------------------------------------------------
// crpu_back
// Arithmetic pipeline: operand conversion, add, multiply or pass-through,
// final conversion to the other form, saturation and the output register.
// ----------------------------------------------------------------------------
module crpu_back #(
  parameter int STEPS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  crpu_pkg::cmd_t  q_cmd,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [127:0]    m_tdata,
  output logic            m_tuser
);
  import crpu_pkg::*;

  typedef struct packed {
    op_t      op;
    operand_t a;
  } tag_a_t;

  typedef struct packed {
    logic        rot;
    logic        ov;
    logic [31:0] re;
    logic [31:0] im;
    logic [30:0] mag;
    logic [31:0] ang;
  } tag_c_t;

  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } sat32_t;

  typedef struct packed {
    logic        ov;
    logic [30:0] val;
  } satm_t;

  localparam int TAG_A_W = $bits(tag_a_t);
  localparam int TAG_B_W = $bits(operand_t);
  localparam int TAG_C_W = $bits(tag_c_t);

  function automatic sat32_t sat32(input logic signed [RW:0] v);
    sat32_t r;
    r.ov = 1'b0;
    r.val = v[31:0];
    if (!(&v[RW:31]) && (|v[RW:31])) begin
      r.ov = 1'b1;
      r.val = v[RW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic satm_t satm(input logic [64:0] v);
    satm_t r;
    r.ov = |v[64:31];
    r.val = r.ov ? 31'h7FFF_FFFF : v[30:0];
    return r;
  endfunction

  logic                   adv;
  tag_a_t                 in_tag_a;
  logic signed [32:0]     a_x;
  logic signed [32:0]     b_x;
  logic                   a_valid;
  logic                   b_valid;
  logic signed [RW-1:0]   a_re;
  logic signed [RW-1:0]   a_im;
  logic [32:0]            a_mag;
  logic [31:0]            a_ang;
  logic [TAG_A_W-1:0]     a_tag_bits;
  logic signed [RW-1:0]   b_re;
  logic signed [RW-1:0]   b_im;
  logic [32:0]            b_mag;
  logic [31:0]            b_ang;
  logic [TAG_B_W-1:0]     b_tag_bits;
  tag_a_t                 ta;
  operand_t               tb;

  logic signed [RW-1:0]   ra;
  logic signed [RW-1:0]   ia;
  logic signed [RW-1:0]   rb;
  logic signed [RW-1:0]   ib;
  sat32_t                 s_re;
  sat32_t                 s_im;
  logic [31:0]            ma;
  logic [31:0]            mb;
  logic [31:0]            aa;
  logic [31:0]            ab;

  logic                   k1_valid;
  logic                   k1_vec;
  logic                   k1_ov;
  logic [31:0]            k1_re;
  logic [31:0]            k1_im;
  logic [63:0]            k1_prod;
  logic [31:0]            k1_ang;
  logic                   k1_vec_next;
  logic                   k1_ov_next;
  logic [31:0]            k1_re_next;
  logic [31:0]            k1_im_next;
  logic [63:0]            k1_prod_next;
  logic [31:0]            k1_ang_next;

  logic [64:0]            k_rnd;
  satm_t                  k_mag;

  logic                   k2_valid;
  logic                   k2_vec;
  logic signed [32:0]     k2_x;
  logic [31:0]            k2_y;
  tag_c_t                 k2_tag;

  logic                   c_valid;
  logic signed [RW-1:0]   c_re;
  logic signed [RW-1:0]   c_im;
  logic [32:0]            c_mag;
  logic [31:0]            c_ang;
  logic [TAG_C_W-1:0]     c_tag_bits;
  tag_c_t                 tc;
  sat32_t                 o_re;
  sat32_t                 o_im;
  satm_t                  o_mag;

  logic [31:0]            res_real;
  logic [31:0]            res_imag;
  logic [30:0]            res_mag;
  logic [31:0]            res_angle;
  logic                   overflow;

  assign adv = !m_tvalid || m_tready;
  assign q_ready = adv;

  always_comb begin
    in_tag_a.op = q_cmd.op;
    in_tag_a.a = q_cmd.a;
    a_x = q_cmd.a.polar ? {1'b0, q_cmd.a.first} : {q_cmd.a.first[31], q_cmd.a.first};
    b_x = q_cmd.b.polar ? {1'b0, q_cmd.b.first} : {q_cmd.b.first[31], q_cmd.b.first};
  end

  crpu_cordic #(.STEPS(STEPS), .TAG_W(TAG_A_W)) u_cordic_a (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (q_valid),
    .in_vec   (q_cmd.op == OP_MUL),
    .in_x     (a_x),
    .in_y     (q_cmd.a.second),
    .in_tag   (in_tag_a),
    .out_valid(a_valid),
    .out_re   (a_re),
    .out_im   (a_im),
    .out_mag  (a_mag),
    .out_ang  (a_ang),
    .out_tag  (a_tag_bits)
  );

  crpu_cordic #(.STEPS(STEPS), .TAG_W(TAG_B_W)) u_cordic_b (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (q_valid),
    .in_vec   (q_cmd.op == OP_MUL),
    .in_x     (b_x),
    .in_y     (q_cmd.b.second),
    .in_tag   (q_cmd.b),
    .out_valid(b_valid),
    .out_re   (b_re),
    .out_im   (b_im),
    .out_mag  (b_mag),
    .out_ang  (b_ang),
    .out_tag  (b_tag_bits)
  );

  always_comb begin
    ta = tag_a_t'(a_tag_bits);
    tb = operand_t'(b_tag_bits);
    ra = ta.a.polar ? a_re : RW'($signed(ta.a.first));
    ia = ta.a.polar ? a_im : RW'($signed(ta.a.second));
    rb = tb.polar ? b_re : RW'($signed(tb.first));
    ib = tb.polar ? b_im : RW'($signed(tb.second));
    s_re = sat32((RW + 1)'(ra) + (RW + 1)'(rb));
    s_im = sat32((RW + 1)'(ia) + (RW + 1)'(ib));
    ma = ta.a.polar ? ta.a.first : a_mag[31:0];
    aa = ta.a.polar ? ta.a.second : a_ang;
    mb = tb.polar ? tb.first : b_mag[31:0];
    ab = tb.polar ? tb.second : b_ang;
  end

  always_comb begin
    k1_vec_next = 1'b1;
    k1_ov_next = 1'b0;
    k1_re_next = '0;
    k1_im_next = '0;
    k1_prod_next = '0;
    k1_ang_next = '0;
    case (ta.op)
      OP_ADD: begin
        k1_re_next = s_re.val;
        k1_im_next = s_im.val;
        k1_ov_next = s_re.ov || s_im.ov;
      end
      OP_MUL: begin
        k1_vec_next = 1'b0;
        k1_prod_next = 64'(ma) * 64'(mb);
        k1_ang_next = aa + ab;
      end
      OP_CONV: begin
        if (ta.a.polar) begin
          k1_vec_next = 1'b0;
          k1_prod_next = 64'(ta.a.first) << FRAC_BITS;
          k1_ang_next = ta.a.second;
        end else begin
          k1_re_next = ta.a.first;
          k1_im_next = ta.a.second;
        end
      end
      default: begin
        k1_vec_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_valid <= 1'b0;
    end else if (adv) begin
      k1_valid <= a_valid && b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_vec <= k1_vec_next;
      k1_ov <= k1_ov_next;
      k1_re <= k1_re_next;
      k1_im <= k1_im_next;
      k1_prod <= k1_prod_next;
      k1_ang <= k1_ang_next;
    end
  end

  always_comb begin
    k_rnd = ({1'b0, k1_prod} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    k_mag = satm(k_rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k2_valid <= 1'b0;
    end else if (adv) begin
      k2_valid <= k1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2_vec <= k1_vec;
      k2_x <= k1_vec ? {k1_re[31], k1_re} : {2'b00, k_mag.val};
      k2_y <= k1_vec ? k1_im : k1_ang;
      k2_tag.rot <= !k1_vec;
      k2_tag.ov <= k1_ov || (!k1_vec && k_mag.ov);
      k2_tag.re <= k1_re;
      k2_tag.im <= k1_im;
      k2_tag.mag <= k_mag.val;
      k2_tag.ang <= k1_ang;
    end
  end

  crpu_cordic #(.STEPS(STEPS), .TAG_W(TAG_C_W)) u_cordic_c (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (k2_valid),
    .in_vec   (k2_vec),
    .in_x     (k2_x),
    .in_y     (k2_y),
    .in_tag   (k2_tag),
    .out_valid(c_valid),
    .out_re   (c_re),
    .out_im   (c_im),
    .out_mag  (c_mag),
    .out_ang  (c_ang),
    .out_tag  (c_tag_bits)
  );

  always_comb begin
    tc = tag_c_t'(c_tag_bits);
    o_re = sat32((RW + 1)'(c_re));
    o_im = sat32((RW + 1)'(c_im));
    o_mag = satm(65'(c_mag));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tc.rot) begin
        res_real <= o_re.val;
        res_imag <= o_im.val;
        res_mag <= tc.mag;
        res_angle <= tc.ang;
        overflow <= tc.ov || o_re.ov || o_im.ov;
      end else begin
        res_real <= tc.re;
        res_imag <= tc.im;
        res_mag <= o_mag.val;
        res_angle <= c_ang;
        overflow <= tc.ov || o_mag.ov;
      end
    end
  end

  assign m_tdata = {1'b0, res_angle, res_mag, res_imag, res_real};
  assign m_tuser = overflow;

endmodule

[hw/rtl/complex_rect_polar_unit.sv]
// ----------------------------------------------------------------------------
// complex_rect_polar_unit
// Complex add, multiply and rectangular/polar conversion on Q15.16 values.
//
// Input transactions carry the operation and two operands on the slave
// stream; every input gives exactly one result transaction on the master
// stream, in order. Each result holds the cartesian and the polar form and
// an overflow flag for saturated values.
// The data path runs through two pipelined CORDIC units in series, with one
// stage per iteration. Throughput is one transaction per cycle while the
// receiver is ready. A four-entry command queue sits ahead of the pipeline.
// When the receiver stalls, the pipeline and the output register hold their
// contents and the queue keeps taking inputs until it is full; s_tready then
// drops. Reset empties the queue and clears every valid flag in the pipeline.
// ----------------------------------------------------------------------------
module complex_rect_polar_unit #(
  parameter int CORDIC_STEPS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // a_first, a_second, b_first, b_second
  input  logic [3:0]    s_tuser,   // func[1:0], a_is_polar, b_is_polar
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // res_real, res_imag, res_mag, res_angle, pad
  output logic          m_tuser    // overflow
);
  import crpu_pkg::*;

  logic q_in_valid;
  logic q_in_ready;
  cmd_t q_in_cmd;
  logic q_out_valid;
  logic q_out_ready;
  cmd_t q_out_cmd;

  crpu_front u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_in_valid),
    .q_ready (q_in_ready),
    .q_cmd   (q_in_cmd)
  );

  crpu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_in_valid),
    .in_ready (q_in_ready),
    .in_cmd   (q_in_cmd),
    .out_valid(q_out_valid),
    .out_ready(q_out_ready),
    .out_cmd  (q_out_cmd)
  );

  crpu_back #(.STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_out_valid),
    .q_ready (q_out_ready),
    .q_cmd   (q_out_cmd),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

[test/tb_complex_rect_polar_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_rect_polar_unit
// Self-checking bench for the complex rectangular/polar unit.
//
// A table of directed transactions covers the operand extremes, every
// operation and the special cases. About 1600 random transactions follow,
// with phases of sender gaps and receiver stalls. Each result is compared, field by
// field, with a typed-in expectation or with a bit-exact CORDIC computation kept in this bench.
// ----------------------------------------------------------------------------
module tb_complex_rect_polar_unit;
  import crpu_pkg::*;

  localparam int STEPS = 32;
  localparam int FRAC = 16;
  localparam int GBITS = 16;
  localparam int LIMIT = 400000;

  typedef struct {
    op_t         op;
    logic        ap;
    logic [31:0] a1;
    logic [31:0] a2;
    logic        bp;
    logic [31:0] b1;
    logic [31:0] b2;
  } item_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [30:0] mag;
    logic [31:0] ang;
    logic        ov;
  } res_t;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic m_tuser;

  complex_rect_polar_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] arctan [0:29] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

  longint unsigned inv_k;
  res_t result_q[$];
  int fail_count = 0;
  int cycles = 0;
  int s_idle = 0;
  int r_stall = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int ov_count = 0;

  function automatic longint unsigned compute_inv_gain();
    longint unsigned p, v, r, b;
    p = 64'd1 << 30;
    for (int i = 0; i < STEPS; i++) if (2 * i < 62) p = p + (p >> (2 * i));
    v = p << 30;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (r == 0) r = 1;
    return (64'd1 << 60) / r;
  endfunction

  function automatic longint unsigned gain_scale(longint unsigned v);
    return (v >> 30) * inv_k + (((v & 64'h3FFFFFFF) * inv_k + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint arctan_at(int i);
    return (i < 30) ? longint'({32'd0, arctan[i]}) : 0;
  endfunction

  function automatic longint sat32(longint v, inout logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned sat_mag(longint unsigned v, inout logic ov);
    if (v > 64'h7FFFFFFF) begin
      ov = 1'b1;
      return 64'h7FFFFFFF;
    end
    return v;
  endfunction

  function automatic void polar_to_cart(longint unsigned mag, logic [31:0] ang,
                                        output longint re, output longint im);
    longint x, y, z, nx;
    logic [31:0] a;
    logic [31:0] t;
    x = longint'(gain_scale(mag << GBITS));
    y = 0;
    a = ang;
    t = a + 32'h40000000;
    if (t > 32'h80000000) begin
      x = -x;
      a = a + 32'h80000000;
    end
    z = longint'($signed(a));
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_at(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_at(i);
      end
      x = nx;
    end
    re = (x + (64'sd1 <<< (GBITS - 1))) >>> GBITS;
    im = (y + (64'sd1 <<< (GBITS - 1))) >>> GBITS;
  endfunction

  function automatic void cart_to_polar(longint re, longint im,
                                        output longint unsigned mag,
                                        output logic [31:0] ang);
    longint x, y, z, nx;
    logic [31:0] base;
    if (re == 0 && im == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    x = re * 65536;
    y = im * 65536;
    z = 0;
    base = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_at(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_at(i);
      end
      x = nx;
    end
    if (x < 0) x = 0;
    mag = (gain_scale(longint'(x)) + (64'd1 << (GBITS - 1))) >> GBITS;
    ang = base + z[31:0];
  endfunction

  function automatic void fold_polar(logic [31:0] f, logic [31:0] s,
                                     output longint unsigned mag, output logic [31:0] ang);
    longint m;
    m = longint'($signed(f));
    ang = s;
    if (m < 0) begin
      m = -m;
      ang = ang + 32'h80000000;
    end
    mag = m;
  endfunction

  function automatic void operand_cart(logic polar, logic [31:0] f, logic [31:0] s,
                                       output longint re, output longint im);
    longint unsigned m;
    logic [31:0] a;
    if (polar) begin
      fold_polar(f, s, m, a);
      polar_to_cart(m, a, re, im);
    end else begin
      re = longint'($signed(f));
      im = longint'($signed(s));
    end
  endfunction

  function automatic void operand_polar(logic polar, logic [31:0] f, logic [31:0] s,
                                        output longint unsigned mag, output logic [31:0] ang);
    if (polar) fold_polar(f, s, mag, ang);
    else cart_to_polar(longint'($signed(f)), longint'($signed(s)), mag, ang);
  endfunction

  function automatic res_t complex_result(item_t it);
    res_t r;
    longint re, im, re2, im2;
    longint unsigned mag, mag2;
    logic [31:0] ang, ang2;
    logic ov;
    re = 0;
    im = 0;
    mag = 0;
    ang = 0;
    ov = 1'b0;
    case (it.op)
      OP_ADD: begin
        operand_cart(it.ap, it.a1, it.a2, re, im);
        operand_cart(it.bp, it.b1, it.b2, re2, im2);
        re = sat32(re + re2, ov);
        im = sat32(im + im2, ov);
        cart_to_polar(re, im, mag, ang);
        mag = sat_mag(mag, ov);
      end
      OP_MUL: begin
        operand_polar(it.ap, it.a1, it.a2, mag, ang);
        operand_polar(it.bp, it.b1, it.b2, mag2, ang2);
        mag = (mag * mag2 + (64'd1 << (FRAC - 1))) >> FRAC;
        mag = sat_mag(mag, ov);
        ang = ang + ang2;
        polar_to_cart(mag, ang, re, im);
        re = sat32(re, ov);
        im = sat32(im, ov);
      end
      OP_CONV: begin
        if (it.ap) begin
          fold_polar(it.a1, it.a2, mag, ang);
          mag = sat_mag(mag, ov);
          polar_to_cart(mag, ang, re, im);
          re = sat32(re, ov);
          im = sat32(im, ov);
        end else begin
          re = longint'($signed(it.a1));
          im = longint'($signed(it.a2));
          cart_to_polar(re, im, mag, ang);
          mag = sat_mag(mag, ov);
        end
      end
      default: ;
    endcase
    r.re = re[31:0];
    r.im = im[31:0];
    r.mag = mag[30:0];
    r.ang = ang;
    r.ov = ov;
    return r;
  endfunction

  function automatic item_t mk(op_t op, logic ap, logic [31:0] a1, logic [31:0] a2,
                               logic bp, logic [31:0] b1, logic [31:0] b2);
    item_t it;
    it.op = op;
    it.ap = ap;
    it.a1 = a1;
    it.a2 = a2;
    it.bp = bp;
    it.b1 = b1;
    it.b2 = b2;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
      2: return 32'($signed($urandom_range(0, 32'h02000000)) - 32'sh01000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(item_t it, res_t want);
    while ($urandom_range(0, 99) < s_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {it.b2, it.b1, it.a2, it.a1};
    s_tuser <= {it.bp, it.ap, it.op};
    do @(posedge clk); while (!s_tready);
    result_q.push_back(want);
    op_count[it.op]++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= r_stall);

  always @(posedge clk) begin
    res_t want;
    res_t got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, result_q.size());
      $display("Mismatches found");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.re = m_tdata[31:0];
      got.im = m_tdata[63:32];
      got.mag = m_tdata[94:64];
      got.ang = m_tdata[126:95];
      got.ov = m_tuser;
      if (result_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result re=%h im=%h mag=%h ang=%h ov=%b", $time,
                 got.re, got.im, got.mag, got.ang, got.ov);
      end else begin
        want = result_q.pop_front();
        if (got.ov) ov_count++;
        if (got != want) begin
          fail_count++;
          $display("%0t: expected re=%h im=%h mag=%h ang=%h ov=%b", $time,
                   want.re, want.im, want.mag, want.ang, want.ov);
          $display("%0t:   actual re=%h im=%h mag=%h ang=%h ov=%b", $time,
                   got.re, got.im, got.mag, got.ang, got.ov);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t row;
    item_t it;
    res_t zero;
    int idle_s [4];
    int idle_r [4];
    op_t op;

    idle_s = '{0, 76, 0, 26};
    idle_r = '{0, 0, 76, 26};
    inv_k = compute_inv_gain();
    zero = '{32'd0, 32'd0, 31'd0, 32'd0, 1'b0};

    // Unused operation code and trivial zero cases, expectation typed in.
    row = '{mk(OP_NONE, 1, 32'h7FFFFFFF, 32'h80000000, 1, 32'h80000000, 32'hFFFFFFFF), 1, zero};
    rows.push_back(row);
    row = '{mk(OP_ADD, 0, 0, 0, 0, 0, 0), 1, zero};
    rows.push_back(row);
    row = '{mk(OP_CONV, 0, 0, 0, 1, 32'hFFFFFFFF, 32'hFFFFFFFF), 1, zero};
    rows.push_back(row);
    row = '{mk(OP_CONV, 1, 0, 32'h12345678, 0, 0, 0), 1,
            '{32'd0, 32'd0, 31'd0, 32'h12345678, 1'b0}};
    rows.push_back(row);
    // Remaining directed rows go through the predictor.
    row.typed = 0;
    row.it = mk(OP_ADD, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    rows.push_back(row);
    row.it = mk(OP_ADD, 0, 32'h80000000, 32'h80000000, 0, 32'h80000000, 32'h80000000);
    rows.push_back(row);
    row.it = mk(OP_ADD, 1, 32'h00010000, 32'h40000000, 0, 32'h00010000, 32'h0);
    rows.push_back(row);
    row.it = mk(OP_ADD, 1, 32'h80000000, 32'h0, 1, 32'h80000000, 32'h80000000);
    rows.push_back(row);
    row.it = mk(OP_MUL, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    rows.push_back(row);
    row.it = mk(OP_MUL, 1, 32'h80000000, 32'h80000000, 1, 32'h00010000, 32'h0);
    rows.push_back(row);
    row.it = mk(OP_MUL, 0, 32'hFFFF0000, 32'h0, 0, 32'h0, 32'h00020000);
    rows.push_back(row);
    row.it = mk(OP_MUL, 0, 32'h0, 32'h0, 1, 32'h00030000, 32'h20000000);
    rows.push_back(row);
    row.it = mk(OP_CONV, 1, 32'hFFFE0000, 32'h10000000, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    rows.push_back(row);
    row.it = mk(OP_CONV, 1, 32'h80000000, 32'h40000001, 0, 0, 0);
    rows.push_back(row);
    row.it = mk(OP_CONV, 1, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0);
    rows.push_back(row);
    row.it = mk(OP_CONV, 1, 32'h00010000, 32'hBFFFFFFF, 0, 0, 0);
    rows.push_back(row);
    row.it = mk(OP_CONV, 0, 32'h80000000, 32'h7FFFFFFF, 1, 32'h80000000, 32'h80000000);
    rows.push_back(row);
    row.it = mk(OP_CONV, 0, 32'hFFFF0000, 32'h0, 0, 0, 0);
    rows.push_back(row);
    row.it = mk(OP_CONV, 0, 32'h0, 32'h80000000, 0, 0, 0);
    rows.push_back(row);
    row.it = mk(OP_CONV, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0);
    rows.push_back(row);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      send(rows[i].it, rows[i].typed ? rows[i].want : complex_result(rows[i].it));
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      s_idle = idle_s[ph];
      r_stall = idle_r[ph];
      for (int n = 0; n < 400; n++) begin
        op = ($urandom_range(0, 15) == 0) ? OP_NONE : op_t'($urandom_range(0, 2));
        it = mk(op, $urandom_range(0, 1), rand_word(), rand_word(),
                $urandom_range(0, 1), rand_word(), rand_word());
        send(it, complex_result(it));
      end
      if (ph == 1) drain();
    end
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (2 * STEPS + 40) @(posedge clk);

    $display("Covered %0d add, %0d multiply, %0d convert and %0d unused-code transactions,",
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d results saturated, under four sender/receiver gap patterns.", ov_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
